// ----- rtl/core/pild_pkg.sv -----
// Shared types and constants of the packed integer list decoder.
// No dependencies; every other file of the block imports this package.
package pild_pkg;

  localparam int unsigned TypeBits  = 2;
  localparam int unsigned CountBits = 6;
  localparam int unsigned TagBits   = 6;
  localparam int unsigned AccBits   = 63;
  localparam int unsigned ValBits   = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } q_item_t;

  typedef struct packed {
    logic               valid;
    logic [ValBits-1:0] value;
    logic               last_list;
  } emit_t;

endpackage

// ----- rtl/core/pild_queue.sv -----
// Front of the decoder: accepts input words into a two-entry queue.
// Depends on pild_pkg.
module pild_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pild_pkg::q_item_t in_item_i,
  output logic              q_valid_o,
  output pild_pkg::q_item_t q_item_o,
  input  logic              q_pop_i
);
  import pild_pkg::*;

  q_item_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (q_pop_i) rd_q <= !rd_q;
      if (push && !q_pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push && q_pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

endmodule

// ----- rtl/core/pild_engine.sv -----
// Back of the decoder: bit-serial list parser, one stream bit or one
// zero-width element per cycle while the result side has room. Depends on pild_pkg.
module pild_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  pild_pkg::q_item_t q_item_i,
  output logic              q_pop_o,
  input  logic              out_free_i,
  output pild_pkg::emit_t   emit_o,
  output logic              flush_o
);
  import pild_pkg::*;

  localparam logic [2:0] PhType  = 3'd0;
  localparam logic [2:0] PhCount = 3'd1;
  localparam logic [2:0] PhPos   = 3'd2;
  localparam logic [2:0] PhWidth = 3'd3;
  localparam logic [2:0] PhTag   = 3'd4;
  localparam logic [2:0] PhSign  = 3'd5;
  localparam logic [2:0] PhMag   = 3'd6;

  logic [2:0]         phase_q, phase_d;
  logic [1:0]         kind_q, kind_d;
  logic               known_q, known_d;
  logic [5:0]         left_q, left_d;
  logic               allpos_q, allpos_d;
  logic [5:0]         width_q, width_d;
  logic               sign_q, sign_d;
  logic [AccBits-1:0] acc_q, acc_d;
  logic [5:0]         fbits_q, fbits_d;
  logic [ValBits-1:0] sum_q, sum_d;
  logic               zrun_q, zrun_d;
  logic [7:0]         byte_q, byte_d;
  logic [3:0]         bcnt_q, bcnt_d;
  logic               act_q, act_d;

  logic [AccBits-1:0] acc_n;
  logic [ValBits-1:0] base, mag, val;
  logic [5:0]         left_n, w_n;
  logic               do_after, do_body;

  assign acc_n  = {acc_q[AccBits-2:0], byte_q[7]};
  assign base   = kind_q[1] ? sum_q : '0;
  assign mag    = {1'b0, acc_n};
  assign val    = sign_q ? (base - mag) : (base + mag);
  assign left_n = (left_q != 6'd0) ? (left_q - 6'd1) : 6'd0;

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    known_d  = known_q;
    left_d   = left_q;
    allpos_d = allpos_q;
    width_d  = width_q;
    sign_d   = sign_q;
    acc_d    = acc_q;
    fbits_d  = fbits_q;
    sum_d    = sum_q;
    zrun_d   = zrun_q;
    byte_d   = byte_q;
    bcnt_d   = bcnt_q;
    act_d    = act_q;
    emit_o   = '0;
    flush_o  = 1'b0;
    q_pop_o  = 1'b0;
    do_after = 1'b0;
    do_body  = 1'b0;
    w_n      = width_q;

    if (out_free_i) begin
      if (act_q && zrun_q) begin
        emit_o.valid     = 1'b1;
        emit_o.value     = base;
        emit_o.last_list = (left_q == 6'd1);
        do_after         = 1'b1;
      end else if (act_q && bcnt_q != 4'd0) begin
        byte_d = {byte_q[6:0], 1'b0};
        bcnt_d = bcnt_q - 4'd1;
        if (fbits_q == 6'd1) begin
          acc_d = '0;
          unique case (phase_q)
            PhType: begin
              known_d = (acc_n[AccBits-1:2] == '0);
              kind_d  = acc_n[1:0];
              phase_d = PhCount;
              fbits_d = 6'(CountBits);
            end
            PhCount: begin
              left_d  = acc_n[5:0];
              phase_d = PhPos;
              fbits_d = 6'd1;
            end
            PhPos: begin
              allpos_d = acc_n[0];
              sum_d    = '0;
              if (!known_q || (kind_q[0] && left_q == 6'd0)) begin
                phase_d = PhType;
                fbits_d = 6'(TypeBits);
              end else if (!kind_q[0]) begin
                phase_d = PhWidth;
                fbits_d = 6'(TagBits);
              end else begin
                phase_d = PhTag;
                fbits_d = 6'(TagBits);
              end
            end
            PhWidth: begin
              width_d = acc_n[5:0];
              w_n     = acc_n[5:0];
              if (left_q == 6'd0) begin
                phase_d = PhType;
                fbits_d = 6'(TypeBits);
              end else begin
                do_body = 1'b1;
              end
            end
            PhTag: begin
              width_d = acc_n[5:0];
              w_n     = acc_n[5:0];
              do_body = 1'b1;
            end
            PhSign: begin
              sign_d = acc_n[0];
              if (width_q == 6'd0) begin
                emit_o.valid     = 1'b1;
                emit_o.value     = base;
                emit_o.last_list = (left_q == 6'd1);
                do_after         = 1'b1;
              end else begin
                phase_d = PhMag;
                fbits_d = width_q;
              end
            end
            PhMag: begin
              emit_o.valid     = 1'b1;
              emit_o.value     = val;
              emit_o.last_list = (left_q == 6'd1);
              if (kind_q[1]) sum_d = val;
              do_after = 1'b1;
            end
            default: begin
              phase_d = PhType;
              fbits_d = 6'(TypeBits);
            end
          endcase
        end else begin
          acc_d   = acc_n;
          fbits_d = fbits_q - 6'd1;
        end
      end else begin
        flush_o = act_q;
        act_d   = 1'b0;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          byte_d  = q_item_i.data_byte;
          bcnt_d  = 4'd8;
          act_d   = 1'b1;
          if (q_item_i.restart) begin
            phase_d  = PhType;
            kind_d   = '0;
            known_d  = 1'b0;
            left_d   = '0;
            allpos_d = 1'b0;
            width_d  = '0;
            sign_d   = 1'b0;
            acc_d    = '0;
            fbits_d  = 6'(TypeBits);
            sum_d    = '0;
            zrun_d   = 1'b0;
          end
        end
      end

      if (do_after) begin
        left_d = left_n;
        acc_d  = '0;
        if (left_n == 6'd0) begin
          zrun_d  = 1'b0;
          phase_d = PhType;
          fbits_d = 6'(TypeBits);
        end else if (kind_q[0]) begin
          zrun_d  = 1'b0;
          phase_d = PhTag;
          fbits_d = 6'(TagBits);
        end else begin
          do_body = 1'b1;
        end
      end

      if (do_body) begin
        if (!allpos_q) begin
          phase_d = PhSign;
          fbits_d = 6'd1;
        end else begin
          sign_d = 1'b0;
          if (w_n != 6'd0) begin
            phase_d = PhMag;
            fbits_d = w_n;
          end else begin
            zrun_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhType;
      kind_q   <= '0;
      known_q  <= 1'b0;
      left_q   <= '0;
      allpos_q <= 1'b0;
      width_q  <= '0;
      sign_q   <= 1'b0;
      acc_q    <= '0;
      fbits_q  <= 6'(TypeBits);
      sum_q    <= '0;
      zrun_q   <= 1'b0;
      byte_q   <= '0;
      bcnt_q   <= '0;
      act_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      known_q  <= known_d;
      left_q   <= left_d;
      allpos_q <= allpos_d;
      width_q  <= width_d;
      sign_q   <= sign_d;
      acc_q    <= acc_d;
      fbits_q  <= fbits_d;
      sum_q    <= sum_d;
      zrun_q   <= zrun_d;
      byte_q   <= byte_d;
      bcnt_q   <= bcnt_d;
      act_q    <= act_d;
    end
  end

endmodule

// ----- rtl/core/pild_out.sv -----
// Result side: holds the newest result back until the word's end is known,
// then marks the last one and feeds the output register. Depends on pild_pkg.
module pild_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pild_pkg::emit_t             emit_i,
  input  logic                        flush_i,
  output logic                        out_free_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pild_pkg::ValBits-1:0] value_o,
  output logic                        last_of_list_o,
  output logic                        last_of_run_o
);
  import pild_pkg::*;

  logic [ValBits-1:0] pval_q;
  logic               plist_q;
  logic               pv_q;
  logic               ov_q;
  logic               move;

  assign out_free_o  = !ov_q || !out_stall_i;
  assign move        = pv_q && (emit_i.valid || flush_i);
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (emit_i.valid) pv_q <= 1'b1;
      else if (flush_i) pv_q <= 1'b0;
      if (move) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      pval_q  <= emit_i.value;
      plist_q <= emit_i.last_list;
    end
    if (move) begin
      value_o        <= pval_q;
      last_of_list_o <= plist_q;
      last_of_run_o  <= flush_i;
    end
  end

endmodule

// ----- rtl/core/packed_integer_list_decoder_top.sv -----
// Top level of the packed integer list decoder: queue, parser, result stage.
// Depends on pild_pkg, pild_queue, pild_engine and pild_out.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o   | data_byte_i, restart_i
//  out     | output    | out_valid_o/out_stall_i | value_o, last_of_list_o, last_of_run_o
//
// The parser takes a word one stream bit at a time, then closes it and loads the
// next in a step of its own; each unsigned zero-width element also takes a step.
// The parser holds while the output register is full and stalled.
// The input queue holds two words, so input is taken while the parser works.
// Reset clears all parser and handshake state; restart_i clears the parser
// state at the start of its word.
module packed_integer_list_decoder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pild_pkg::ValBits-1:0] value_o,
  output logic                               last_of_list_o,
  output logic                               last_of_run_o
);
  import pild_pkg::*;

  q_item_t            in_item, q_item;
  logic               q_valid, q_pop;
  logic               out_free, flush;
  emit_t              emit;
  logic [ValBits-1:0] value;

  assign in_item.data_byte = data_byte_i;
  assign in_item.restart   = restart_i;
  assign value_o           = signed'(value);

  pild_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  pild_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_free_i (out_free),
    .emit_o     (emit),
    .flush_o    (flush)
  );

  pild_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .emit_i         (emit),
    .flush_i        (flush),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value),
    .last_of_list_o (last_of_list_o),
    .last_of_run_o  (last_of_run_o)
  );

`ifndef ASSERT_OFF
  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("parser popped an empty queue");

  a_emit_or_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit.valid && flush)) else $error("result and word close in one cycle");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid || flush) |-> out_free) else $error("result moved into a full stage");
`endif

endmodule

// ----- tb/sv/packed_integer_list_decoder_top_tb.sv -----
// Testbench for packed_integer_list_decoder_top: packs integer lists into a byte stream,
// predicts every decoded element and checks each result word under varied handshake idling.
// Depends on pild_pkg and the decoder RTL.
module packed_integer_list_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pild_pkg::*;

  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 100;
  localparam int QuietLimit  = 3000;
  localparam int MaxPerWord  = 64;
  localparam int MaxReports  = 100;

  typedef enum logic [2:0] {
    FLD_TYPE, FLD_COUNT, FLD_POS, FLD_WIDTH, FLD_TAG, FLD_SIGN, FLD_MAG
  } field_e;

  typedef enum logic [1:0] {
    KIND_FIXED, KIND_TAGGED, KIND_DELTA_FIXED, KIND_DELTA_TAGGED
  } kind_e;

  typedef struct packed {
    logic [ValBits-1:0] value;
    logic               last_list;
    logic               last_run;
  } element_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [7:0]                 data_byte_i;
  logic                       restart_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [ValBits-1:0]  value_o;
  logic                       last_of_list_o;
  logic                       last_of_run_o;

  element_t elements_due[$];
  bit       stream_q[$];
  bit       restart_next;
  int       send_idle;
  int       recv_stall;
  int       hold_left;
  int       words_sent;
  int       results_seen;
  int       err_count;

  // decoder state mirror
  field_e             pd_field;
  kind_e              pd_kind;
  bit                 pd_known;
  logic [5:0]         pd_left;
  bit                 pd_pos;
  logic [5:0]         pd_width;
  bit                 pd_sign;
  logic [AccBits-1:0] pd_acc;
  int                 pd_bits;
  logic [ValBits-1:0] pd_sum;
  int                 pd_emitted;

  always #1 clk_i = ~clk_i;

  packed_integer_list_decoder_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .last_of_list_o (last_of_list_o),
    .last_of_run_o  (last_of_run_o)
  );

  function automatic void open_field(field_e f, int n);
    pd_field = f;
    pd_acc   = '0;
    pd_bits  = n;
  endfunction

  function automatic bit list_tagged();
    return pd_kind == KIND_TAGGED || pd_kind == KIND_DELTA_TAGGED;
  endfunction

  function automatic bit list_delta();
    return pd_kind == KIND_DELTA_FIXED || pd_kind == KIND_DELTA_TAGGED;
  endfunction

  function automatic void clear_decoder();
    pd_kind  = KIND_FIXED;
    pd_known = 1'b0;
    pd_left  = '0;
    pd_pos   = 1'b0;
    pd_width = '0;
    pd_sign  = 1'b0;
    pd_sum   = '0;
    open_field(FLD_TYPE, TypeBits);
  endfunction

  function automatic void push_element(logic [ValBits-1:0] v);
    element_t e;
    e.value = v;
    if (list_delta()) begin
      pd_sum  = pd_sum + v;
      e.value = pd_sum;
    end
    e.last_list = (pd_left == 6'd1);
    e.last_run  = 1'b0;
    if (pd_emitted < MaxPerWord) begin
      elements_due.insert(elements_due.size(), e);
      pd_emitted++;
    end
  endfunction

  // true when the next element shares the width and starts at once
  function automatic bit next_element();
    if (pd_left != 0) pd_left--;
    if (pd_left == 0) begin
      open_field(FLD_TYPE, TypeBits);
      return 1'b0;
    end
    if (list_tagged()) begin
      open_field(FLD_TAG, TagBits);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void start_element();
    while (1'b1) begin
      if (!pd_pos) begin
        open_field(FLD_SIGN, 1);
        return;
      end
      pd_sign = 1'b0;
      if (pd_width != 0) begin
        open_field(FLD_MAG, pd_width);
        return;
      end
      push_element('0);
      if (!next_element()) return;
    end
  endfunction

  function automatic void close_field();
    logic [ValBits-1:0] v;
    case (pd_field)
      FLD_TYPE: begin
        pd_known = (pd_acc <= 3);
        pd_kind  = kind_e'(pd_acc[1:0]);
        open_field(FLD_COUNT, CountBits);
      end
      FLD_COUNT: begin
        pd_left = pd_acc[5:0];
        open_field(FLD_POS, 1);
      end
      FLD_POS: begin
        pd_pos = pd_acc[0];
        pd_sum = '0;
        if (!pd_known) open_field(FLD_TYPE, TypeBits);
        else if (!list_tagged()) open_field(FLD_WIDTH, TagBits);
        else if (pd_left == 0) open_field(FLD_TYPE, TypeBits);
        else open_field(FLD_TAG, TagBits);
      end
      FLD_WIDTH: begin
        pd_width = pd_acc[5:0];
        if (pd_left == 0) open_field(FLD_TYPE, TypeBits);
        else start_element();
      end
      FLD_TAG: begin
        pd_width = pd_acc[5:0];
        start_element();
      end
      FLD_SIGN: begin
        pd_sign = pd_acc[0];
        if (pd_width == 0) begin
          push_element('0);
          if (next_element()) start_element();
        end else begin
          open_field(FLD_MAG, pd_width);
        end
      end
      FLD_MAG: begin
        v = {1'b0, pd_acc};
        if (pd_sign) v = -v;
        push_element(v);
        if (next_element()) start_element();
      end
      default: open_field(FLD_TYPE, TypeBits);
    endcase
  endfunction

  function automatic void decode_word(logic [7:0] b, bit rs);
    element_t tail;
    int       before_cnt;
    if (rs) clear_decoder();
    pd_emitted = 0;
    before_cnt = elements_due.size();
    for (int i = 7; i >= 0; i--) begin
      if (pd_bits == 0) open_field(FLD_TYPE, TypeBits);
      pd_acc = {pd_acc[AccBits-2:0], b[i]};
      pd_bits--;
      if (pd_bits == 0) close_field();
    end
    if (elements_due.size() > before_cnt) begin
      tail = elements_due.pop_back();
      tail.last_run = 1'b1;
      elements_due.insert(elements_due.size(), tail);
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < MaxReports) $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_result();
    element_t want;
    results_seen++;
    if (elements_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result value %h", value_o));
      return;
    end
    want = elements_due.pop_front();
    if (value_o !== want.value)
      report_mismatch($sformatf("value %h, expected %h", value_o, want.value));
    if (last_of_list_o !== want.last_list)
      report_mismatch($sformatf("last_of_list %b, expected %b (value %h)",
                                last_of_list_o, want.last_list, want.value));
    if (last_of_run_o !== want.last_run)
      report_mismatch($sformatf("last_of_run %b, expected %b (value %h)",
                                last_of_run_o, want.last_run, want.value));
  endtask

  task automatic send_word(input logic [7:0] b, input bit rs);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    restart_i   <= rs;
    do @(posedge clk_i); while (in_stall_o);
    decode_word(b, rs);
    words_sent++;
  endtask

  function automatic void put_bits(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) stream_q.insert(stream_q.size(), v[i]);
  endfunction

  function automatic int pick_width(int wmax);
    int r;
    r = $urandom_range(99);
    if (r < 12) return 0;
    if (r < 20) return wmax;
    return $urandom_range(wmax);
  endfunction

  function automatic logic [63:0] rand_mag(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(5) == 0) v = '1;
    return v & ((64'd1 << w) - 64'd1);
  endfunction

  function automatic void put_list(kind_e kind, int count, bit pos, int wmax);
    int w;
    bit is_tagged;
    is_tagged = (kind == KIND_TAGGED || kind == KIND_DELTA_TAGGED);
    w = 0;
    put_bits(kind, TypeBits);
    put_bits(count, CountBits);
    put_bits(pos, 1);
    if (!is_tagged) begin
      w = pick_width(wmax);
      put_bits(w, TagBits);
    end
    for (int e = 0; e < count; e++) begin
      if (is_tagged) begin
        w = pick_width(wmax);
        put_bits(w, TagBits);
      end
      if (!pos) put_bits($urandom_range(1), 1);
      put_bits(rand_mag(w), w);
    end
  endfunction

  // sends every complete word; with pad set, the tail is filled with random bits
  task automatic ship_bits(input bit pad);
    logic [7:0] b;
    while (stream_q.size() >= 8 || (pad && stream_q.size() > 0)) begin
      while (stream_q.size() < 8) stream_q.insert(stream_q.size(), 1'($urandom_range(1)));
      for (int i = 7; i >= 0; i--) b[i] = stream_q.pop_front();
      send_word(b, restart_next);
      restart_next = 1'b0;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (elements_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_lists();
    send_idle    = 0;
    recv_stall   = 0;
    restart_next = 1'b1;
    // tagged signed: widest negative, signed zero width, negative zero
    put_bits(KIND_TAGGED, TypeBits);
    put_bits(3, CountBits);
    put_bits(0, 1);
    put_bits(63, TagBits);
    put_bits(1, 1);
    put_bits({1'b0, {63{1'b1}}}, 63);
    put_bits(0, TagBits);
    put_bits(1, 1);
    put_bits(5, TagBits);
    put_bits(1, 1);
    put_bits(0, 5);
    // delta sum wraps through zero
    put_bits(KIND_DELTA_TAGGED, TypeBits);
    put_bits(2, CountBits);
    put_bits(0, 1);
    put_bits(1, TagBits);
    put_bits(1, 1);
    put_bits(1, 1);
    put_bits(1, TagBits);
    put_bits(0, 1);
    put_bits(1, 1);
    put_bits(KIND_DELTA_FIXED, TypeBits);
    put_bits(2, CountBits);
    put_bits(1, 1);
    put_bits(3, TagBits);
    put_bits(3'b111, 3);
    put_bits(3'b101, 3);
    // 63 unsigned zero-width elements out of one word
    put_bits(KIND_FIXED, TypeBits);
    put_bits(63, CountBits);
    put_bits(1, 1);
    put_bits(0, TagBits);
    // empty lists
    put_bits(KIND_FIXED, TypeBits);
    put_bits(0, CountBits);
    put_bits(0, 1);
    put_bits(17, TagBits);
    put_bits(KIND_TAGGED, TypeBits);
    put_bits(0, CountBits);
    put_bits(1, 1);
    ship_bits(1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_streams(int words, int idle_pct, int stall_pct);
    int start_cnt;
    int r;
    int cnt;
    int wmax;
    int keep;
    send_idle    = idle_pct;
    recv_stall   = stall_pct;
    start_cnt    = words_sent;
    restart_next = 1'b1;
    while (words_sent - start_cnt < words) begin
      r = $urandom_range(99);
      if (r < 10) begin
        ship_bits(1'b1);
        send_word(8'($urandom), $urandom_range(3) == 0);
        restart_next = 1'b1;
      end else begin
        cnt  = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(6);
        wmax = (cnt > 10) ? 4 : (($urandom_range(3) == 0) ? 63 : 10);
        put_list(kind_e'($urandom_range(3)), cnt, $urandom_range(1), wmax);
        if (r < 16) begin
          // list cut short, then restarted
          keep = $urandom_range(stream_q.size());
          while (stream_q.size() > keep) void'(stream_q.pop_back());
          ship_bits(1'b1);
          restart_next = 1'b1;
        end else if ($urandom_range(9) == 0) begin
          ship_bits(1'b1);
          restart_next = 1'b1;
        end else begin
          ship_bits(1'b0);
        end
      end
    end
    ship_bits(1'b1);
    wait_drained();
  endtask

  task automatic test_output_hold();
    send_idle    = 0;
    recv_stall   = 0;
    restart_next = 1'b1;
    hold_left    = HoldCycles;
    repeat (3) put_list(KIND_FIXED, 40, 1'b1, 2);
    ship_bits(1'b1);
    wait_drained();
  endtask

  // result side: random stall, long hold on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("no word moved for %0d cycles, %0d results outstanding",
             quiet, elements_due.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    restart_i    = 1'b0;
    hold_left    = 0;
    send_idle    = 0;
    recv_stall   = 0;
    words_sent   = 0;
    results_seen = 0;
    err_count    = 0;
    clear_decoder();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lists();
    test_random_streams(95, 0, 0);
    test_random_streams(95, 81, 0);
    test_random_streams(95, 0, 81);
    test_random_streams(95, 29, 29);
    test_output_hold();

    recv_stall = 0;
    repeat (DrainCycles) @(posedge clk_i);
    $display("Decoded %0d stream bytes into %0d checked elements: all four list kinds,",
             words_sent, results_seen);
    $display("signed and unsigned widths 0..63, restarts, noise, idling and a long output hold.");
    if (err_count == 0 && elements_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
